[design/gpk_pkg.sv]
// Shared types and constants for the GUID property key parser.
// Used by gpk_char_class and guid_property_key_parser; no dependencies.
package gpk_pkg;

    // Character codes (UTF-16 code units)
    localparam logic [15:0] CHAR_NUL    = 16'h0000;
    localparam logic [15:0] CHAR_SPACE  = 16'h0020;
    localparam logic [15:0] CHAR_COMMA  = 16'h002C;
    localparam logic [15:0] CHAR_MINUS  = 16'h002D;
    localparam logic [15:0] CHAR_ZERO   = 16'h0030;
    localparam logic [15:0] CHAR_NINE   = 16'h0039;
    localparam logic [15:0] CHAR_UPPER_A = 16'h0041;
    localparam logic [15:0] CHAR_UPPER_F = 16'h0046;
    localparam logic [15:0] CHAR_LOWER_A = 16'h0061;
    localparam logic [15:0] CHAR_LOWER_F = 16'h0066;
    localparam logic [15:0] CHAR_LBRACE = 16'h007B;
    localparam logic [15:0] CHAR_RBRACE = 16'h007D;

    // GUID text layout
    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_FIRST     = 6'd0;
    localparam logic [POS_W-1:0] POS_DATA1_END = 6'd8;
    localparam logic [POS_W-1:0] POS_DASH1     = 6'd9;
    localparam logic [POS_W-1:0] POS_DASH2     = 6'd14;
    localparam logic [POS_W-1:0] POS_DASH3     = 6'd19;
    localparam logic [POS_W-1:0] POS_DASH4     = 6'd24;
    localparam logic [POS_W-1:0] GUID_LAST_POS = 6'd37;

    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_GUID   = 6'b000001,
        PH_SKIP   = 6'b000010,
        PH_MINUS1 = 6'b000100,
        PH_MINUS2 = 6'b001000,
        PH_DIGITS = 6'b010000,
        PH_DONE   = 6'b100000
    } phase_t;

    typedef enum logic [1:0] {
        V_UNDECIDED = 2'd0,
        V_OK        = 2'd1,
        V_INVALID   = 2'd2
    } verdict_t;

    // Classification of one character
    typedef struct packed {
        logic       is_nul;
        logic       is_space;
        logic       is_comma;
        logic       is_minus;
        logic       is_lbrace;
        logic       is_rbrace;
        logic       is_hex;
        logic       is_dec;
        logic [3:0] nibble;
    } char_class_t;

    // Tail byte committed at a GUID position: {hit, byte index}
    typedef struct packed {
        logic       hit;
        logic [2:0] idx;
    } tail_slot_t;

    function automatic tail_slot_t tail_slot(input logic [POS_W-1:0] pos);
        tail_slot_t s;
        s.hit = 1'b1;
        unique case (pos)
            6'd21:   s.idx = 3'd0;
            6'd24:   s.idx = 3'd1;
            6'd26:   s.idx = 3'd2;
            6'd28:   s.idx = 3'd3;
            6'd30:   s.idx = 3'd4;
            6'd32:   s.idx = 3'd5;
            6'd34:   s.idx = 3'd6;
            6'd37:   s.idx = 3'd7;
            default: begin
                s.hit = 1'b0;
                s.idx = 3'd0;
            end
        endcase
        return s;
    endfunction

endpackage

[design/guid_property_key_parser.sv]
// Top level of the GUID property key parser: input register, per-character
// parse step and result register. Depends on gpk_pkg and gpk_char_class.
//
// The block reads a property key "{XXXXXXXX-XXXX-XXXX-XXXX-XXXXXXXXXXXX}" plus
// a decimal id as a stream of 16-bit characters, one per word on the s_
// channel; a zero character ends the string and yields exactly one result
// word on the m_ channel, after which the parser is ready for the next string.
// It takes one character per clock cycle while no result waits on m_ready;
// the parse step between the input register and the result register sets
// that figure. Once a terminator passes the parse step, its result is offered
// on m_valid from the result register. While a result waits on m_ready the
// parse step holds; the input register fills and s_ready drops until it is taken.
module guid_property_key_parser (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_char_code,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [31:0] m_guid_data1,
    output logic [15:0] m_guid_data2,
    output logic [15:0] m_guid_data3,
    output logic [63:0] m_guid_tail_bytes,
    output logic [31:0] m_property_id
);

    // input register
    logic        in_valid_reg;
    logic [15:0] in_char_reg;

    // parser state
    gpk_pkg::phase_t            phase_reg, phase_next;
    gpk_pkg::verdict_t          verdict_reg, verdict_next;
    logic [gpk_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [31:0]                group_reg, group_next;
    logic [31:0]                data1_reg, data1_next;
    logic [15:0]                data2_reg, data2_next;
    logic [15:0]                data3_reg, data3_next;
    logic [63:0]                tail_reg, tail_next;
    logic [31:0]                id_reg, id_next;
    logic                       comma_reg, comma_next;
    logic                       minus_reg, minus_next;

    // result register
    logic        m_valid_reg;
    logic        m_status_reg;
    logic [31:0] m_data1_reg;
    logic [15:0] m_data2_reg;
    logic [15:0] m_data3_reg;
    logic [63:0] m_tail_reg;
    logic [31:0] m_id_reg;

    gpk_pkg::char_class_t cls;
    gpk_pkg::tail_slot_t  slot;
    logic        out_free;
    logic        advance;
    logic        guid_ok;
    logic        early_ok;
    logic        final_ok;
    logic [31:0] id_signed;
    logic [31:0] id_digit;
    logic [31:0] group_shift;

    gpk_char_class u_char_class (
        .char_code (in_char_reg),
        .cls       (cls)
    );

    // handshake: the stored word moves on whenever the result slot can take it
    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_code;
        end
    end

    // per-character helpers
    always_comb begin
        slot        = gpk_pkg::tail_slot(pos_reg);
        group_shift = {group_reg[27:0], cls.nibble};
        id_signed   = minus_reg ? (32'd0 - id_reg) : id_reg;
        id_digit    = 32'(id_reg * 32'(gpk_pkg::DECIMAL_BASE)) + {28'd0, cls.nibble};

        if (pos_reg == gpk_pkg::POS_FIRST) begin
            guid_ok = cls.is_lbrace;
        end else if (pos_reg == gpk_pkg::POS_DASH1 || pos_reg == gpk_pkg::POS_DASH2 ||
                     pos_reg == gpk_pkg::POS_DASH3 || pos_reg == gpk_pkg::POS_DASH4) begin
            guid_ok = cls.is_minus;
        end else if (pos_reg == gpk_pkg::GUID_LAST_POS) begin
            guid_ok = cls.is_rbrace;
        end else begin
            guid_ok = cls.is_hex;
        end

        // terminator while reading sign or digits closes with ok
        early_ok = (phase_reg == gpk_pkg::PH_MINUS1) || (phase_reg == gpk_pkg::PH_MINUS2) ||
                   (phase_reg == gpk_pkg::PH_DIGITS);
        final_ok = early_ok ||
                   (phase_reg == gpk_pkg::PH_DONE && verdict_reg == gpk_pkg::V_OK);
    end

    // parse step
    always_comb begin
        phase_next   = phase_reg;
        verdict_next = verdict_reg;
        pos_next     = pos_reg;
        group_next   = group_reg;
        data1_next   = data1_reg;
        data2_next   = data2_reg;
        data3_next   = data3_reg;
        tail_next    = tail_reg;
        id_next      = id_reg;
        comma_next   = comma_reg;
        minus_next   = minus_reg;

        if (advance) begin
            if (cls.is_nul) begin
                // string done: back to the start
                phase_next   = gpk_pkg::PH_GUID;
                verdict_next = gpk_pkg::V_UNDECIDED;
                pos_next     = gpk_pkg::POS_FIRST;
                group_next   = 32'd0;
                data1_next   = 32'd0;
                data2_next   = 16'd0;
                data3_next   = 16'd0;
                tail_next    = 64'd0;
                id_next      = 32'd0;
                comma_next   = 1'b0;
                minus_next   = 1'b0;
            end else begin
                unique case (phase_reg)
                    gpk_pkg::PH_GUID: begin
                        if (!guid_ok) begin
                            verdict_next = gpk_pkg::V_INVALID;
                            phase_next   = gpk_pkg::PH_DONE;
                        end else begin
                            if (cls.is_hex && pos_reg != gpk_pkg::POS_FIRST &&
                                pos_reg != gpk_pkg::GUID_LAST_POS &&
                                pos_reg != gpk_pkg::POS_DASH1 &&
                                pos_reg != gpk_pkg::POS_DASH2 &&
                                pos_reg != gpk_pkg::POS_DASH3 &&
                                pos_reg != gpk_pkg::POS_DASH4) begin
                                group_next = group_shift;
                            end
                            // commit a group at the end of its span
                            if (pos_reg == gpk_pkg::POS_DATA1_END) begin
                                data1_next = group_next;
                            end
                            if (pos_reg == gpk_pkg::POS_DASH2) begin
                                data2_next = group_next[15:0];
                            end
                            if (pos_reg == gpk_pkg::POS_DASH3) begin
                                data3_next = group_next[15:0];
                            end
                            for (int k = 0; k < 8; k++) begin
                                if (slot.hit && slot.idx == 3'(k)) begin
                                    tail_next[63-8*k -: 8] = group_next[7:0];
                                end
                            end
                            if (pos_reg == gpk_pkg::GUID_LAST_POS) begin
                                phase_next = gpk_pkg::PH_SKIP;
                            end else begin
                                pos_next = pos_reg + 6'd1;
                            end
                        end
                    end
                    gpk_pkg::PH_SKIP, gpk_pkg::PH_MINUS1,
                    gpk_pkg::PH_MINUS2, gpk_pkg::PH_DIGITS: begin
                        if (phase_reg != gpk_pkg::PH_DIGITS && cls.is_space) begin
                            // spaces skipped
                        end else if (phase_reg == gpk_pkg::PH_SKIP && cls.is_comma) begin
                            if (comma_reg) begin
                                id_next      = 32'd0;
                                verdict_next = gpk_pkg::V_OK;
                                phase_next   = gpk_pkg::PH_DONE;
                            end else begin
                                comma_next = 1'b1;
                            end
                        end else if (phase_reg == gpk_pkg::PH_SKIP && cls.is_minus) begin
                            if (comma_reg) begin
                                minus_next = 1'b1;
                                phase_next = gpk_pkg::PH_DIGITS;
                            end else begin
                                phase_next = gpk_pkg::PH_MINUS1;
                            end
                        end else if (phase_reg == gpk_pkg::PH_MINUS1 && cls.is_minus) begin
                            minus_next = 1'b1;
                            phase_next = gpk_pkg::PH_MINUS2;
                        end else if (cls.is_dec) begin
                            phase_next = gpk_pkg::PH_DIGITS;
                            id_next    = id_digit;
                        end else begin
                            // non-digit closes the id
                            id_next      = id_signed;
                            verdict_next = gpk_pkg::V_OK;
                            phase_next   = gpk_pkg::PH_DONE;
                        end
                    end
                    gpk_pkg::PH_DONE: begin
                        // ignore until terminator
                    end
                    default: begin
                        phase_next = gpk_pkg::PH_GUID;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= gpk_pkg::PH_GUID;
            verdict_reg <= gpk_pkg::V_UNDECIDED;
            pos_reg     <= gpk_pkg::POS_FIRST;
            group_reg   <= 32'd0;
            data1_reg   <= 32'd0;
            data2_reg   <= 16'd0;
            data3_reg   <= 16'd0;
            tail_reg    <= 64'd0;
            id_reg      <= 32'd0;
            comma_reg   <= 1'b0;
            minus_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            verdict_reg <= verdict_next;
            pos_reg     <= pos_next;
            group_reg   <= group_next;
            data1_reg   <= data1_next;
            data2_reg   <= data2_next;
            data3_reg   <= data3_next;
            tail_reg    <= tail_next;
            id_reg      <= id_next;
            comma_reg   <= comma_next;
            minus_reg   <= minus_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && cls.is_nul) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && cls.is_nul) begin
            m_status_reg <= !final_ok;
            m_data1_reg  <= data1_reg;
            m_data2_reg  <= data2_reg;
            m_data3_reg  <= data3_reg;
            m_tail_reg   <= tail_reg;
            m_id_reg     <= !final_ok ? 32'd0 : (early_ok ? id_signed : id_reg);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_status_reg;
    assign m_guid_data1      = m_data1_reg;
    assign m_guid_data2      = m_data2_reg;
    assign m_guid_data3      = m_data3_reg;
    assign m_guid_tail_bytes = m_tail_reg;
    assign m_property_id     = m_id_reg;

    // checks
    a_phase_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(phase_reg))
        else $error("phase register not one-hot");

    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= gpk_pkg::GUID_LAST_POS)
        else $error("GUID position out of range");

    a_skip_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == gpk_pkg::PH_SKIP |-> pos_reg == gpk_pkg::GUID_LAST_POS)
        else $error("left GUID before its last position");

    a_guid_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == gpk_pkg::PH_GUID |-> !comma_reg && !minus_reg && id_reg == 32'd0)
        else $error("id state set while reading GUID");

    a_term_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && cls.is_nul |=> phase_reg == gpk_pkg::PH_GUID &&
                                  pos_reg == gpk_pkg::POS_FIRST && m_valid_reg)
        else $error("terminator did not restart parser and post a result");

    a_fail_zero_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg |-> m_id_reg == 32'd0)
        else $error("failed result carries a nonzero id");

endmodule

[design/gpk_char_class.sv]
// Character classifier: decodes one 16-bit code unit into the classes the
// parser needs (hex/decimal digit value, punctuation). Depends on gpk_pkg.
module gpk_char_class (
    input  logic [15:0]          char_code,
    output gpk_pkg::char_class_t cls
);

    logic is_upper;
    logic is_lower;
    logic [15:0] hex_off;

    always_comb begin
        cls.is_nul    = (char_code == gpk_pkg::CHAR_NUL);
        cls.is_space  = (char_code == gpk_pkg::CHAR_SPACE);
        cls.is_comma  = (char_code == gpk_pkg::CHAR_COMMA);
        cls.is_minus  = (char_code == gpk_pkg::CHAR_MINUS);
        cls.is_lbrace = (char_code == gpk_pkg::CHAR_LBRACE);
        cls.is_rbrace = (char_code == gpk_pkg::CHAR_RBRACE);
        cls.is_dec    = (char_code >= gpk_pkg::CHAR_ZERO) &&
                        (char_code <= gpk_pkg::CHAR_NINE);
        is_upper      = (char_code >= gpk_pkg::CHAR_UPPER_A) &&
                        (char_code <= gpk_pkg::CHAR_UPPER_F);
        is_lower      = (char_code >= gpk_pkg::CHAR_LOWER_A) &&
                        (char_code <= gpk_pkg::CHAR_LOWER_F);
        cls.is_hex    = cls.is_dec || is_upper || is_lower;

        // digit value: letters map to 10..15
        if (is_upper) begin
            hex_off = char_code - gpk_pkg::CHAR_UPPER_A + 16'd10;
        end else if (is_lower) begin
            hex_off = char_code - gpk_pkg::CHAR_LOWER_A + 16'd10;
        end else begin
            hex_off = char_code - gpk_pkg::CHAR_ZERO;
        end
        cls.nibble = hex_off[3:0];
    end

endmodule

[tb/sv/guid_property_key_parser_test.sv]
// Self-checking testbench for guid_property_key_parser: streams property key text one
// character word at a time, predicts each parse result as the text goes in and checks it.
// Depends on gpk_pkg and the guid_property_key_parser RTL.
module guid_property_key_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHAR_TARGET      = 1550;
    localparam int STRING_TARGET    = 70;
    localparam int MID_DRAIN_STRING = 45;
    localparam int LONG_HOLD_AFTER  = 30;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int IDLE_LIMIT       = 4000;
    localparam int SETTLE_CYCLES    = 10;

    // Characters just outside the digit and letter ranges, plus the braces
    localparam logic [15:0] EDGE_CHARS [8] = '{16'h002F, 16'h003A, 16'h0040, 16'h0047,
                                               16'h0060, 16'h0067, 16'h007B, 16'h007D};

    typedef enum {HEX_RANDOM, HEX_UPPER_F, HEX_LOWER_F, HEX_ZERO} hex_style_t;

    typedef struct {
        logic        status;
        logic [31:0] data1;
        logic [15:0] data2;
        logic [15:0] data3;
        logic [63:0] tail;
        logic [31:0] prop_id;
    } key_result_t;

    typedef struct {
        logic [15:0] ch;
        bit          drain_first;
    } text_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [15:0] s_char_code = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_status;
    logic [31:0] m_guid_data1;
    logic [15:0] m_guid_data2;
    logic [15:0] m_guid_data3;
    logic [63:0] m_guid_tail_bytes;
    logic [31:0] m_property_id;

    guid_property_key_parser DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_char_code       (s_char_code),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_guid_data1      (m_guid_data1),
        .m_guid_data2      (m_guid_data2),
        .m_guid_data3      (m_guid_data3),
        .m_guid_tail_bytes (m_guid_tail_bytes),
        .m_property_id     (m_property_id)
    );

    always #5 aclk = ~aclk;

    // Text waiting to be sent and parse results waiting to come back
    text_word_t  text_q[$];
    key_result_t key_q[$];
    bit          drain_next = 1'b0;

    int error_count = 0;
    int n_strings = 0;
    int total_chars = 0;
    int chars_taken = 0;
    int results_predicted = 0;
    int results_seen = 0;
    int ok_count = 0;
    int rejected_count = 0;
    int idle_cycles = 0;

    // Parser model state
    gpk_pkg::phase_t             ph;
    gpk_pkg::verdict_t           vd;
    logic [gpk_pkg::POS_W-1:0]   pos;
    logic [31:0]                 grp_acc;
    logic [31:0]                 grp1;
    logic [15:0]                 grp2;
    logic [15:0]                 grp3;
    logic [63:0]                 tail_acc;
    logic [31:0]                 id_acc;
    logic                        comma_seen;
    logic                        minus_taken;

    task automatic clear_parser();
        ph = gpk_pkg::PH_GUID;
        vd = gpk_pkg::V_UNDECIDED;
        pos = '0;
        grp_acc = '0;
        grp1 = '0;
        grp2 = '0;
        grp3 = '0;
        tail_acc = '0;
        id_acc = '0;
        comma_seen = 1'b0;
        minus_taken = 1'b0;
    endtask

    // Close the id: apply the sign and settle on ok
    task automatic accept_id();
        if (minus_taken) begin
            id_acc = 32'd0 - id_acc;
        end
        vd = gpk_pkg::V_OK;
        ph = gpk_pkg::PH_DONE;
    endtask

    task automatic take_digit(input logic [15:0] c);
        logic [15:0] d;
        d = c - gpk_pkg::CHAR_ZERO;
        if (c >= gpk_pkg::CHAR_ZERO && c <= gpk_pkg::CHAR_NINE) begin
            id_acc = id_acc * 32'(gpk_pkg::DECIMAL_BASE) + {28'd0, d[3:0]};
        end else begin
            accept_id();
        end
    endtask

    // Advance the model by one accepted character; a terminator yields a result
    task automatic parse_char(input logic [15:0] c);
        logic        good;
        logic [15:0] nib;
        key_result_t r;
        if (c == gpk_pkg::CHAR_NUL) begin
            if (ph == gpk_pkg::PH_MINUS1 || ph == gpk_pkg::PH_MINUS2 ||
                ph == gpk_pkg::PH_DIGITS) begin
                accept_id();
            end
            if (ph != gpk_pkg::PH_DONE) begin
                vd = gpk_pkg::V_INVALID;
            end
            r.status  = (vd != gpk_pkg::V_OK);
            r.data1   = grp1;
            r.data2   = grp2;
            r.data3   = grp3;
            r.tail    = tail_acc;
            r.prop_id = r.status ? 32'd0 : id_acc;
            key_q.push_back(r);
            results_predicted++;
            clear_parser();
            return;
        end
        case (ph)
            gpk_pkg::PH_GUID: begin
                good = 1'b0;
                nib = '0;
                if (pos == gpk_pkg::POS_FIRST) begin
                    good = (c == gpk_pkg::CHAR_LBRACE);
                end else if (pos == gpk_pkg::POS_DASH1 || pos == gpk_pkg::POS_DASH2 ||
                             pos == gpk_pkg::POS_DASH3 || pos == gpk_pkg::POS_DASH4) begin
                    good = (c == gpk_pkg::CHAR_MINUS);
                end else if (pos == gpk_pkg::GUID_LAST_POS) begin
                    good = (c == gpk_pkg::CHAR_RBRACE);
                end else begin
                    if (c >= gpk_pkg::CHAR_ZERO && c <= gpk_pkg::CHAR_NINE) begin
                        good = 1'b1;
                        nib = c - gpk_pkg::CHAR_ZERO;
                    end else if (c >= gpk_pkg::CHAR_UPPER_A && c <= gpk_pkg::CHAR_UPPER_F) begin
                        good = 1'b1;
                        nib = c - gpk_pkg::CHAR_UPPER_A + 16'd10;
                    end else if (c >= gpk_pkg::CHAR_LOWER_A && c <= gpk_pkg::CHAR_LOWER_F) begin
                        good = 1'b1;
                        nib = c - gpk_pkg::CHAR_LOWER_A + 16'd10;
                    end
                    if (good) begin
                        grp_acc = {grp_acc[27:0], nib[3:0]};
                    end
                end
                if (!good) begin
                    vd = gpk_pkg::V_INVALID;
                    ph = gpk_pkg::PH_DONE;
                end else begin
                    // commit a group once its whole span is valid
                    if (pos == gpk_pkg::POS_DATA1_END) grp1 = grp_acc;
                    if (pos == gpk_pkg::POS_DASH2) grp2 = grp_acc[15:0];
                    if (pos == gpk_pkg::POS_DASH3) grp3 = grp_acc[15:0];
                    case (pos)
                        6'd21: tail_acc[63:56] = grp_acc[7:0];
                        6'd24: tail_acc[55:48] = grp_acc[7:0];
                        6'd26: tail_acc[47:40] = grp_acc[7:0];
                        6'd28: tail_acc[39:32] = grp_acc[7:0];
                        6'd30: tail_acc[31:24] = grp_acc[7:0];
                        6'd32: tail_acc[23:16] = grp_acc[7:0];
                        6'd34: tail_acc[15:8]  = grp_acc[7:0];
                        6'd37: tail_acc[7:0]   = grp_acc[7:0];
                        default: ;
                    endcase
                    if (pos == gpk_pkg::GUID_LAST_POS) begin
                        ph = gpk_pkg::PH_SKIP;
                    end else begin
                        pos = pos + 1'b1;
                    end
                end
            end
            gpk_pkg::PH_SKIP: begin
                if (c == gpk_pkg::CHAR_COMMA) begin
                    if (comma_seen) begin
                        id_acc = '0;
                        vd = gpk_pkg::V_OK;
                        ph = gpk_pkg::PH_DONE;
                    end else begin
                        comma_seen = 1'b1;
                    end
                end else if (c == gpk_pkg::CHAR_MINUS) begin
                    if (comma_seen) begin
                        minus_taken = 1'b1;
                        ph = gpk_pkg::PH_DIGITS;
                    end else begin
                        ph = gpk_pkg::PH_MINUS1;
                    end
                end else if (c != gpk_pkg::CHAR_SPACE) begin
                    ph = gpk_pkg::PH_DIGITS;
                    take_digit(c);
                end
            end
            gpk_pkg::PH_MINUS1: begin
                if (c == gpk_pkg::CHAR_MINUS) begin
                    minus_taken = 1'b1;
                    ph = gpk_pkg::PH_MINUS2;
                end else if (c != gpk_pkg::CHAR_SPACE) begin
                    ph = gpk_pkg::PH_DIGITS;
                    take_digit(c);
                end
            end
            gpk_pkg::PH_MINUS2: begin
                if (c != gpk_pkg::CHAR_SPACE) begin
                    ph = gpk_pkg::PH_DIGITS;
                    take_digit(c);
                end
            end
            gpk_pkg::PH_DIGITS: take_digit(c);
            default: ;
        endcase
    endtask

    // Text building
    task automatic add_char(input logic [15:0] c);
        text_word_t w;
        w.ch = c;
        w.drain_first = drain_next;
        drain_next = 1'b0;
        text_q.push_back(w);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            add_char({8'h00, s[i]});
        end
    endtask

    task automatic end_string();
        add_char(gpk_pkg::CHAR_NUL);
        n_strings++;
    endtask

    // Braced GUID text, cut short before stop_at, with bad_ch put at bad_at
    task automatic add_guid(input hex_style_t style, input int stop_at, input int bad_at,
                            input logic [15:0] bad_ch);
        logic [15:0] c;
        int          k;
        for (int p = 0; p < stop_at && p <= gpk_pkg::GUID_LAST_POS; p++) begin
            if (p == bad_at) begin
                c = bad_ch;
            end else if (p == gpk_pkg::POS_FIRST) begin
                c = gpk_pkg::CHAR_LBRACE;
            end else if (p == gpk_pkg::POS_DASH1 || p == gpk_pkg::POS_DASH2 ||
                         p == gpk_pkg::POS_DASH3 || p == gpk_pkg::POS_DASH4) begin
                c = gpk_pkg::CHAR_MINUS;
            end else if (p == gpk_pkg::GUID_LAST_POS) begin
                c = gpk_pkg::CHAR_RBRACE;
            end else begin
                case (style)
                    HEX_UPPER_F: c = gpk_pkg::CHAR_UPPER_F;
                    HEX_LOWER_F: c = gpk_pkg::CHAR_LOWER_F;
                    HEX_ZERO:    c = gpk_pkg::CHAR_ZERO;
                    default: begin
                        k = $urandom_range(0, 21);
                        if (k < 10) c = gpk_pkg::CHAR_ZERO + 16'(k);
                        else if (k < 16) c = gpk_pkg::CHAR_UPPER_A + 16'(k - 10);
                        else c = gpk_pkg::CHAR_LOWER_A + 16'(k - 16);
                    end
                endcase
            end
            add_char(c);
        end
    endtask

    // Text after the GUID: long ids, well-formed id syntax, or loose token mix
    task automatic add_random_tail();
        int          r;
        logic [15:0] c;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            add_char(gpk_pkg::CHAR_COMMA);
            repeat ($urandom_range(10, 20)) begin
                add_char(gpk_pkg::CHAR_ZERO + 16'($urandom_range(0, 9)));
            end
        end else if (r <= 5) begin
            repeat ($urandom_range(0, 2)) add_char(gpk_pkg::CHAR_SPACE);
            if ($urandom_range(0, 1)) add_char(gpk_pkg::CHAR_COMMA);
            repeat ($urandom_range(0, 2)) add_char(gpk_pkg::CHAR_SPACE);
            repeat ($urandom_range(0, 2)) begin
                add_char(gpk_pkg::CHAR_MINUS);
                repeat ($urandom_range(0, 1)) add_char(gpk_pkg::CHAR_SPACE);
            end
            repeat ($urandom_range(1, 10)) begin
                add_char(gpk_pkg::CHAR_ZERO + 16'($urandom_range(0, 9)));
            end
            if ($urandom_range(0, 3) == 0) add_char(16'($urandom_range(1, 65535)));
        end else begin
            repeat ($urandom_range(0, 14)) begin
                r = $urandom_range(0, 99);
                if (r < 40) c = gpk_pkg::CHAR_ZERO + 16'($urandom_range(0, 9));
                else if (r < 58) c = gpk_pkg::CHAR_SPACE;
                else if (r < 70) c = gpk_pkg::CHAR_COMMA;
                else if (r < 85) c = gpk_pkg::CHAR_MINUS;
                else if (r < 93) c = 16'($urandom_range(33, 126));
                else c = 16'($urandom_range(1, 65535));
                add_char(c);
            end
        end
    endtask

    // Sender: bursts of words with random gaps; some words wait for the pipe to empty
    int burst_left = 5;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_char(s_char_code);
                chars_taken++;
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (text_q.size() == 0 ||
                             (text_q[0].drain_first && results_predicted != results_seen)) begin
                    s_valid <= 1'b0;
                end else begin
                    s_char_code <= text_q[0].ch;
                    s_valid <= 1'b1;
                    text_q.pop_front();
                    if (burst_left > 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 4) == 0) begin
                        burst_left = $urandom_range(100, 300);
                        gap_left = 0;
                    end else begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: stall rate redrawn at random among five settings; one long hold-off to back up the block
    int  hold_left = 0;
    int  rx_cycles = 0;
    int  stall_pct = 0;
    bit  long_hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER) begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
            m_ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 50 == 0) begin
                case ($urandom_range(0, 4))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    2: stall_pct = 40;
                    3: stall_pct = 75;
                    default: stall_pct = 90;
                endcase
            end
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    // Result checker: each word against the oldest expectation
    always @(posedge aclk) begin
        key_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (key_q.size() == 0) begin
                $error("result word with no expectation waiting");
                error_count++;
            end else begin
                want = key_q.pop_front();
                check_field("status", 64'(want.status), 64'(m_status));
                check_field("guid_data1", 64'(want.data1), 64'(m_guid_data1));
                check_field("guid_data2", 64'(want.data2), 64'(m_guid_data2));
                check_field("guid_data3", 64'(want.data3), 64'(m_guid_data3));
                check_field("guid_tail_bytes", want.tail, m_guid_tail_bytes);
                check_field("property_id", 64'(want.prop_id), 64'(m_property_id));
                if (want.status) rejected_count++;
                else ok_count++;
            end
            results_seen <= results_seen + 1;
        end
    end

    // Watchdog on cycles with no word moving on either side
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int          kind;
        logic [15:0] bad;
        clear_parser();

        // Directed: empty string, extreme ids, every minus and comma rule
        end_string();
        add_guid(HEX_UPPER_F, 38, -1, '0); add_text(",4294967295"); end_string();
        add_guid(HEX_LOWER_F, 38, -1, '0); add_text(" , -45"); end_string();
        add_guid(HEX_ZERO, 38, -1, '0); add_text("0"); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text("-  - 7 "); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text("- 9"); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text(" ,  ,12"); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text(",-"); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text(", - 5"); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text("-"); end_string();
        // overflow, then words past the decision that must be ignored
        add_guid(HEX_RANDOM, 38, -1, '0); add_text("99999999999x");
        add_char(16'hFFFF); add_char(16'h8000); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text("4294967296"); end_string();
        // terminator while still skipping
        add_guid(HEX_RANDOM, 38, -1, '0); end_string();
        add_guid(HEX_RANDOM, 38, -1, '0); add_text(" ,"); end_string();
        // bad GUID characters at the brace, a hex span, a dash and the closing brace
        add_guid(HEX_RANDOM, 38, 0, 16'h005B); end_string();
        add_guid(HEX_RANDOM, 38, 20, 16'h0067); add_text(",1"); end_string();
        add_guid(HEX_RANDOM, 38, 9, gpk_pkg::CHAR_ZERO); end_string();
        add_guid(HEX_RANDOM, 38, 37, 16'h0029); add_text("12"); end_string();
        // terminator inside the GUID
        add_guid(HEX_RANDOM, 30, -1, '0); end_string();
        add_char(16'hFFFF); add_char(16'h8000); add_char(16'h7FFF); end_string();

        // Random part: mostly well-formed keys, some broken, cut short or noise
        drain_next = 1'b1;
        while (text_q.size() < CHAR_TARGET || n_strings < STRING_TARGET) begin
            if (n_strings == MID_DRAIN_STRING) drain_next = 1'b1;
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                add_guid(HEX_RANDOM, 38, -1, '0);
                add_random_tail();
            end else if (kind < 80) begin
                case ($urandom_range(0, 3))
                    0: bad = EDGE_CHARS[$urandom_range(0, 7)];
                    1: bad = gpk_pkg::CHAR_MINUS;
                    2: bad = 16'($urandom_range(1, 65535));
                    default: bad = gpk_pkg::CHAR_ZERO + 16'($urandom_range(0, 9));
                endcase
                add_guid(HEX_RANDOM, 38, $urandom_range(0, 37), bad);
                add_random_tail();
            end else if (kind < 93) begin
                add_guid(HEX_RANDOM, $urandom_range(0, 37), -1, '0);
            end else begin
                repeat ($urandom_range(0, 8)) add_char(16'($urandom_range(1, 65535)));
            end
            end_string();
        end
        total_chars = text_q.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (chars_taken != total_chars) @(posedge aclk);
        while (results_seen != results_predicted) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (key_q.size() != 0) begin
            $error("%0d expected results never arrived", key_q.size());
            error_count++;
        end

        $display("Sent %0d strings in %0d characters; checked %0d results (%0d ok, %0d rejected).",
                 n_strings, total_chars, ok_count + rejected_count, ok_count, rejected_count);
        $display("Mismatches counted: %0d.", error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
